/* rtl/pedal_calibrate_smooth_defines.svh */
// assertion macros shared by the pedal calibrate and smooth rtl
`ifndef PEDAL_CALIBRATE_SMOOTH_DEFINES_SVH
`define PEDAL_CALIBRATE_SMOOTH_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked outside reset only
`define PCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define PCS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCS_ASSERT(lbl, prop, msg)
`define PCS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/pcs_pkg.sv */
package pcs_pkg;

    localparam int VAL_W      = 7;
    localparam int ECHO_W     = 10;
    localparam int CAL_LOW_W  = 10;
    localparam int CAL_HIGH_W = 11;
    localparam int DEN_W      = 12;
    localparam int QUO_W      = 8;
    localparam int DIV_STEPS  = 8;

    localparam logic [VAL_W-1:0]      MAP_MAX        = 7'd127;
    localparam logic [CAL_LOW_W-1:0]  CAL_LOW_RESET  = 10'd0;
    localparam logic [CAL_HIGH_W-1:0] CAL_HIGH_RESET = 11'd1024;

    // register index codes, taken from paddr[2]
    localparam logic REG_CAL_LOW  = 1'b0;
    localparam logic REG_CAL_HIGH = 1'b1;

    // classification of one sample, handed from front to back
    typedef struct packed {
        logic                  zero_q;
        logic [ECHO_W-1:0]     raw_echo;
        logic [CAL_HIGH_W-1:0] den_mag;
    } pcs_ctl_t;

endpackage

/* rtl/pcs_front.sv */
module pcs_front #(
    parameter int SAMPLE_BITS = 10,
    parameter int DIFF_W      = 10,
    parameter int NUM_W       = 17
) (
    input  logic [SAMPLE_BITS-1:0]         raw_sample,
    input  logic [pcs_pkg::CAL_LOW_W-1:0]  cal_low,
    input  logic [pcs_pkg::CAL_HIGH_W-1:0] cal_high,
    output pcs_pkg::pcs_ctl_t              ctl,
    output logic [NUM_W-1:0]               num_mag
);

    logic signed [DIFF_W:0]           diff_s;
    logic        [DIFF_W:0]           diff_neg;
    logic        [DIFF_W-1:0]         diff_mag;
    logic signed [pcs_pkg::DEN_W-1:0] den_s;
    logic        [pcs_pkg::DEN_W-1:0] den_neg;
    logic        [DIFF_W-1:0]         raw_ext;

    assign raw_ext  = DIFF_W'(raw_sample);
    assign diff_s   = $signed({1'b0, raw_ext}) - $signed((DIFF_W+1)'(cal_low));
    assign diff_neg = -diff_s;
    assign diff_mag = diff_s[DIFF_W] ? diff_neg[DIFF_W-1:0] : diff_s[DIFF_W-1:0];

    assign den_s   = $signed({1'b0, cal_high}) - $signed({2'b00, cal_low});
    assign den_neg = -den_s;

    // times 127 as a shift and subtract
    assign num_mag = {diff_mag, 7'd0} - NUM_W'(diff_mag);

    always_comb
    begin
        ctl.raw_echo = raw_ext[pcs_pkg::ECHO_W-1:0];
        ctl.den_mag  = den_s[pcs_pkg::DEN_W-1] ? den_neg[pcs_pkg::CAL_HIGH_W-1:0]
                                               : den_s[pcs_pkg::CAL_HIGH_W-1:0];
        // empty window, zero numerator or opposite signs all map to zero
        ctl.zero_q   = (den_s == '0) || (diff_s == '0) ||
                       (diff_s[DIFF_W] != den_s[pcs_pkg::DEN_W-1]);
    end

endmodule

/* rtl/pcs_fifo.sv */
`include "pedal_calibrate_smooth_defines.svh"

module pcs_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rd_data,
    output logic         empty
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `PCS_ASSERT_ALWAYS(a_count_range, !rst_n || count_reg != 2'd3, "queue count out of range")
    `PCS_ASSERT(a_push_lands, do_push && !do_pop |=> !empty, "pushed entry lost")

endmodule

/* rtl/pcs_back.sv */
`include "pedal_calibrate_smooth_defines.svh"

module pcs_back #(
    parameter int NUM_W = 17
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fifo_empty,
    input  pcs_pkg::pcs_ctl_t            fifo_ctl,
    input  logic [NUM_W-1:0]             fifo_num,
    output logic                         fifo_pop,
    output logic                         empty,
    input  logic                         pop,
    output logic [pcs_pkg::VAL_W-1:0]    pedal_value,
    output logic                         value_changed,
    output logic [pcs_pkg::ECHO_W-1:0]   raw_echo
);

    localparam int DV_W   = NUM_W + 1;
    localparam int STEP_W = $clog2(pcs_pkg::DIV_STEPS);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DIV    = 2'd1;
    localparam logic [1:0] S_SMOOTH = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [DV_W-1:0]             rem_reg, rem_next;
    logic [DV_W-1:0]             dsh_reg, dsh_next;
    logic [pcs_pkg::QUO_W-1:0]   quo_reg, quo_next;
    logic                        zero_reg, zero_next;
    logic [pcs_pkg::ECHO_W-1:0]  echo_reg, echo_next;
    logic [pcs_pkg::VAL_W-1:0]   cur_reg, cur_next;
    logic [pcs_pkg::VAL_W-1:0]   newer_reg, newer_next;
    logic [pcs_pkg::VAL_W-1:0]   older_reg, older_next;
    logic                        out_valid_reg, out_valid_next;
    logic [pcs_pkg::VAL_W-1:0]   out_value_reg, out_value_next;
    logic                        out_changed_reg, out_changed_next;
    logic [pcs_pkg::ECHO_W-1:0]  out_echo_reg, out_echo_next;

    logic                        ge;
    logic                        slot_free;
    logic [pcs_pkg::VAL_W-1:0]   mapped;
    logic [pcs_pkg::VAL_W+1:0]   sum;
    logic [pcs_pkg::VAL_W-1:0]   avg;

    assign ge        = (rem_reg >= dsh_reg);
    assign slot_free = !out_valid_reg || pop;
    assign mapped    = zero_reg ? '0 :
                       quo_reg[pcs_pkg::QUO_W-1] ? pcs_pkg::MAP_MAX
                                                 : quo_reg[pcs_pkg::VAL_W-1:0];
    assign sum       = 9'(older_reg) + 9'(newer_reg) + 9'(cur_reg) + 9'(mapped);
    assign avg       = sum[pcs_pkg::VAL_W+1:2];

    assign empty         = !out_valid_reg;
    assign pedal_value   = out_value_reg;
    assign value_changed = out_changed_reg;
    assign raw_echo      = out_echo_reg;

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        rem_next         = rem_reg;
        dsh_next         = dsh_reg;
        quo_next         = quo_reg;
        zero_next        = zero_reg;
        echo_next        = echo_reg;
        cur_next         = cur_reg;
        newer_next       = newer_reg;
        older_next       = older_reg;
        out_valid_next   = out_valid_reg && !pop;
        out_value_next   = out_value_reg;
        out_changed_next = out_changed_reg;
        out_echo_next    = out_echo_reg;
        fifo_pop         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!fifo_empty)
                begin
                    fifo_pop   = 1'b1;
                    rem_next   = DV_W'(fifo_num);
                    dsh_next   = DV_W'({fifo_ctl.den_mag, 7'd0});
                    quo_next   = '0;
                    step_next  = '0;
                    zero_next  = fifo_ctl.zero_q;
                    echo_next  = fifo_ctl.raw_echo;
                    state_next = fifo_ctl.zero_q ? S_SMOOTH : S_DIV;
                end
            end
            S_DIV:
            begin
                // restoring step; top quotient bit set means saturate
                if (ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                quo_next  = {quo_reg[pcs_pkg::QUO_W-2:0], ge};
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(pcs_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_SMOOTH;
                end
            end
            S_SMOOTH:
            begin
                if (slot_free)
                begin
                    out_changed_next = 1'b0;
                    out_value_next   = cur_reg;
                    if (mapped != cur_reg)
                    begin
                        older_next = newer_reg;
                        newer_next = cur_reg;
                        if (avg != cur_reg)
                        begin
                            cur_next         = avg;
                            out_value_next   = avg;
                            out_changed_next = 1'b1;
                        end
                    end
                    out_echo_next  = echo_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        step_reg        <= step_next;
        rem_reg         <= rem_next;
        dsh_reg         <= dsh_next;
        quo_reg         <= quo_next;
        zero_reg        <= zero_next;
        echo_reg        <= echo_next;
        out_value_reg   <= out_value_next;
        out_changed_reg <= out_changed_next;
        out_echo_reg    <= out_echo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            newer_reg     <= '0;
            older_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            newer_reg     <= newer_next;
            older_reg     <= older_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a waiting result always shows the live smoothed value
    `PCS_ASSERT(a_out_tracks_cur, out_valid_reg |-> out_value_reg == cur_reg, "result stale")
    `PCS_ASSERT(a_out_held, out_valid_reg && !pop |=> !empty && $stable(raw_echo), "result lost")

endmodule

/* rtl/pedal_calibrate_smooth.sv */
// channel   direction  handshake                  payload
// config    in         psel penable pwrite pready paddr pwdata / prdata
// sample    in         push / full                raw_sample
// result    out        empty / pop                pedal_value value_changed raw_echo
//
// a sample is written into a two-entry queue; the back end then takes it,
// runs an eight-step restoring divider and a smoothing step, and skips the
// divider when the mapped value is trivially zero.
// a result waits in the output register until popped; the next sample is
// divided meanwhile, and stalls only at the smoothing step.
// asynchronous active-low reset clears calibration to 0..1024 and history to 0.
module pedal_calibrate_smooth #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       push,
    output logic                       full,
    input  logic [SAMPLE_BITS-1:0]     raw_sample,
    output logic                       empty,
    input  logic                       pop,
    output logic [pcs_pkg::VAL_W-1:0]  pedal_value,
    output logic                       value_changed,
    output logic [pcs_pkg::ECHO_W-1:0] raw_echo
);

    localparam int DIFF_W  = (SAMPLE_BITS > pcs_pkg::CAL_LOW_W) ? SAMPLE_BITS
                                                                : pcs_pkg::CAL_LOW_W;
    localparam int NUM_W   = DIFF_W + 7;
    localparam int CTL_W   = $bits(pcs_pkg::pcs_ctl_t);
    localparam int ENTRY_W = CTL_W + NUM_W;

    logic [pcs_pkg::CAL_LOW_W-1:0]  cal_low_reg, cal_low_next;
    logic [pcs_pkg::CAL_HIGH_W-1:0] cal_high_reg, cal_high_next;
    logic                           wr_en;

    pcs_pkg::pcs_ctl_t front_ctl;
    logic [NUM_W-1:0]  front_num;
    logic [ENTRY_W-1:0] q_rd_data;
    logic              q_empty;
    logic              q_pop;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cal_low_next  = cal_low_reg;
        cal_high_next = cal_high_reg;
        prdata        = '0;
        unique case (paddr[2])
            pcs_pkg::REG_CAL_LOW:
            begin
                prdata = 32'(cal_low_reg);
                if (wr_en)
                begin
                    cal_low_next = pwdata[pcs_pkg::CAL_LOW_W-1:0];
                end
            end
            pcs_pkg::REG_CAL_HIGH:
            begin
                prdata = 32'(cal_high_reg);
                if (wr_en)
                begin
                    cal_high_next = pwdata[pcs_pkg::CAL_HIGH_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_low_reg  <= pcs_pkg::CAL_LOW_RESET;
            cal_high_reg <= pcs_pkg::CAL_HIGH_RESET;
        end
        else
        begin
            cal_low_reg  <= cal_low_next;
            cal_high_reg <= cal_high_next;
        end
    end

    pcs_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DIFF_W      (DIFF_W),
        .NUM_W       (NUM_W)
    ) u_front (
        .raw_sample (raw_sample),
        .cal_low    (cal_low_reg),
        .cal_high   (cal_high_reg),
        .ctl        (front_ctl),
        .num_mag    (front_num)
    );

    pcs_fifo #(
        .W (ENTRY_W)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data ({front_ctl, front_num}),
        .full    (full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    pcs_back #(
        .NUM_W (NUM_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .fifo_empty    (q_empty),
        .fifo_ctl      (pcs_pkg::pcs_ctl_t'(q_rd_data[ENTRY_W-1:NUM_W])),
        .fifo_num      (q_rd_data[NUM_W-1:0]),
        .fifo_pop      (q_pop),
        .empty         (empty),
        .pop           (pop),
        .pedal_value   (pedal_value),
        .value_changed (value_changed),
        .raw_echo      (raw_echo)
    );

endmodule
